// ===== src/date_time_to_decimal_year_macros.svh =====
// assertion macros for the date and time to decimal year block
`ifndef DATE_TIME_TO_DECIMAL_YEAR_MACROS_SVH
`define DATE_TIME_TO_DECIMAL_YEAR_MACROS_SVH

// same-cycle implication, checked out of reset
`define DTDY_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtdy: same-cycle check failed");

// next-cycle implication, checked out of reset
`define DTDY_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtdy: next-cycle check failed");

`endif

// ===== src/dtdy_pkg.sv =====
// shared types, constants and calendar tables for the decimal year block
`timescale 1ns / 1ps

package dtdy_pkg;

    // field widths
    localparam int unsigned YEAR_W      = 14;
    localparam int unsigned MONTH_W     = 4;
    localparam int unsigned DAY_W       = 5;
    localparam int unsigned HOUR_W      = 5;
    localparam int unsigned MIN_W       = 6;
    localparam int unsigned SEC_W       = 6;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_W       = 46;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned FRAC_BITS   = 32;

    // internal widths
    localparam int unsigned DAYS_W      = 9;
    localparam int unsigned ELAPSED_W   = 25;
    localparam int unsigned SUM_W       = 27;
    localparam int unsigned MOD_W       = 18;
    localparam int unsigned RECIP_SHIFT = 50;
    localparam int unsigned RECIP_W     = 33;
    localparam int unsigned QUOT_W      = 33;
    localparam int unsigned PROD_W      = ELAPSED_W + RECIP_W;
    localparam int unsigned QM_W        = QUOT_W + MOD_W;
    localparam int unsigned PRESHIFT    = RECIP_SHIFT - ELAPSED_W;

    // range limits
    localparam logic [YEAR_W-1:0]  YEAR_LO        = 14'd1583;
    localparam logic [YEAR_W-1:0]  YEAR_HI        = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_CARRY_MAX = 14'd10000;
    localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
    localparam logic [HOUR_W-1:0]  HOUR_HI        = 5'd24;
    localparam logic [MIN_W-1:0]   MIN_MAX        = 6'd59;
    localparam logic [SEC_W-1:0]   SEC_MAX        = 6'd60;

    // seconds per unit
    localparam logic [SUM_W-1:0] SEC_PER_DAY  = 27'd86400;
    localparam logic [SUM_W-1:0] SEC_PER_HOUR = 27'd3600;
    localparam logic [SUM_W-1:0] SEC_PER_MIN  = 27'd60;

    // year length in seconds is days * 675 * 2^7; the 2^7 folds into the shift
    localparam logic [MOD_W-1:0] MOD_365 = 18'd246375;
    localparam logic [MOD_W-1:0] MOD_366 = 18'd247050;
    localparam logic [RECIP_W-1:0] RECIP_365 =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd246375);
    localparam logic [RECIP_W-1:0] RECIP_366 =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd247050);

    // divisibility by 25: multiply by the inverse mod 2^14 and compare
    localparam logic [YEAR_W-1:0] INV_25    = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

    // per-item tag carried down the pipeline
    typedef struct packed {
        logic              ok;
        logic              leap;
        logic [YEAR_W-1:0] year;
    } t_tag;

    // gregorian leap year test
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] p;
        logic              div25;
        p     = y * INV_25;
        div25 = (p <= DIV25_LIM);
        return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
    endfunction

    // length of a month in a common year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] d;
        case (m)
            4'd1:    d = 5'd31;
            4'd2:    d = 5'd28;
            4'd3:    d = 5'd31;
            4'd4:    d = 5'd30;
            4'd5:    d = 5'd31;
            4'd6:    d = 5'd30;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd31;
            4'd9:    d = 5'd30;
            4'd10:   d = 5'd31;
            4'd11:   d = 5'd30;
            4'd12:   d = 5'd31;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

    // days before the first of a month in a common year
    function automatic logic [DAYS_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DAYS_W-1:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== src/date_time_to_decimal_year.sv =====
// top level: gregorian date and time to q32 decimal year, streaming in and out
// path: the input register, then the register stages s2, s3, s4 and s5, then
//   the output register, which drives the result on the output
// throughput: one transaction per cycle; the whole pipeline holds while the
//   output register is full and not taken
// reset: synchronous active-low i_rst_n clears all stage valid bits
`timescale 1ns / 1ps
`include "date_time_to_decimal_year_macros.svh"

module date_time_to_decimal_year (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28], second[39:34]
    input  logic [dtdy_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // decimal_year_q32[45:0], zero fill[47:46]
    output logic [dtdy_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // valid_res[0]
    output logic                             o_m_axis_tuser
);
    import dtdy_pkg::*;

    logic                  w_en;
    logic                  r_in_vld;
    logic [IN_TDATA_W-1:0] r_in_data;
    t_tag                  w_tag;
    logic [ELAPSED_W-1:0]  w_elapsed;
    logic                  r_s2_vld;
    t_tag                  r_s2_tag;
    logic [ELAPSED_W-1:0]  r_s2_elapsed;
    logic                  w_s5_vld;
    t_tag                  w_s5_tag;
    logic [QUOT_W-1:0]     w_s5_quot;
    logic                  r_out_vld;
    logic                  r_out_ok;
    logic [OUT_W-1:0]      r_out_dec, n_out_dec;

    // pipeline advances whenever the output register is free or being taken
    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // check and elapsed seconds
    dtdy_elapsed u_elapsed (
        .i_year    (r_in_data[13:0]),
        .i_month   (r_in_data[17:14]),
        .i_day     (r_in_data[22:18]),
        .i_hour    (r_in_data[27:23]),
        .i_minute  (r_in_data[33:28]),
        .i_second  (r_in_data[39:34]),
        .o_tag     (w_tag),
        .o_elapsed (w_elapsed)
    );

    // fraction of the year
    dtdy_frac u_frac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (r_s2_vld),
        .i_tag     (r_s2_tag),
        .i_elapsed (r_s2_elapsed),
        .o_vld     (w_s5_vld),
        .o_tag     (w_s5_tag),
        .o_quot    (w_s5_quot)
    );

    // whole years plus fraction, zero for an invalid item; carry of an overlong fraction goes into the year
    always_comb begin
        if (w_s5_tag.ok) begin
            n_out_dec = OUT_W'({w_s5_tag.year, FRAC_BITS'(0)}) + OUT_W'(w_s5_quot);
        end else begin
            n_out_dec = '0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld  <= i_s_axis_tvalid;
            r_s2_vld  <= r_in_vld;
            r_out_vld <= w_s5_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_data    <= i_s_axis_tdata;
            r_s2_tag     <= w_tag;
            r_s2_elapsed <= w_elapsed;
            r_out_ok     <= w_s5_tag.ok;
            r_out_dec    <= n_out_dec;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_out_dec};
    assign o_m_axis_tuser  = r_out_ok;

    // checks
    `DTDY_ASSERT_IMPLY(a_invalid_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata == '0)
    `DTDY_ASSERT_IMPLY(a_year_range, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser,
        (o_m_axis_tdata[45:32] >= YEAR_LO) && (o_m_axis_tdata[45:32] <= YEAR_CARRY_MAX))
    `DTDY_ASSERT_IMPLY(a_stall_holds_input, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready, !o_s_axis_tready)
    `DTDY_ASSERT_NEXT(a_in_capture, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, r_in_vld)

endmodule

// ===== src/dtdy_elapsed.sv =====
// range check and elapsed seconds since the start of the year
`timescale 1ns / 1ps

module dtdy_elapsed (
    input  logic [dtdy_pkg::YEAR_W-1:0]    i_year,
    input  logic [dtdy_pkg::MONTH_W-1:0]   i_month,
    input  logic [dtdy_pkg::DAY_W-1:0]     i_day,
    input  logic [dtdy_pkg::HOUR_W-1:0]    i_hour,
    input  logic [dtdy_pkg::MIN_W-1:0]     i_minute,
    input  logic [dtdy_pkg::SEC_W-1:0]     i_second,
    output dtdy_pkg::t_tag                 o_tag,
    output logic [dtdy_pkg::ELAPSED_W-1:0] o_elapsed
);
    import dtdy_pkg::*;

    logic              w_leap;
    logic [DAY_W-1:0]  w_mdays;
    logic [DAYS_W-1:0] w_days;
    logic [SUM_W-1:0]  w_sum;

    // leap year and month length
    always_comb begin
        w_leap  = is_leap(i_year);
        w_mdays = month_len(i_month) +
                  DAY_W'((i_month == MONTH_FEB) && w_leap);
    end

    // field checks
    always_comb begin
        o_tag.leap = w_leap;
        o_tag.year = i_year;
        o_tag.ok   = (i_year >= YEAR_LO) && (i_year <= YEAR_HI) &&
                     (i_month >= MONTH_JAN) && (i_month <= MONTH_DEC) &&
                     (i_day != '0) && (i_day <= w_mdays) &&
                     (i_hour <= HOUR_HI) && (i_minute <= MIN_MAX) &&
                     (i_second <= SEC_MAX);
    end

    // day of year and seconds, garbage for invalid items is masked later
    always_comb begin
        w_days = days_before(i_month) + DAYS_W'(i_day) - DAYS_W'(1) +
                 DAYS_W'((i_month > MONTH_FEB) && w_leap);
        w_sum  = SUM_W'(w_days) * SEC_PER_DAY + SUM_W'(i_hour) * SEC_PER_HOUR +
                 SUM_W'(i_minute) * SEC_PER_MIN + SUM_W'(i_second);
        o_elapsed = w_sum[ELAPSED_W-1:0];
    end

endmodule

// ===== src/dtdy_frac.sv =====
// pipelined divide of elapsed seconds by the year length, 32 fraction bits
`timescale 1ns / 1ps

module dtdy_frac (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  dtdy_pkg::t_tag                 i_tag,
    input  logic [dtdy_pkg::ELAPSED_W-1:0] i_elapsed,
    output logic                           o_vld,
    output dtdy_pkg::t_tag                 o_tag,
    output logic [dtdy_pkg::QUOT_W-1:0]    o_quot
);
    import dtdy_pkg::*;

    logic                 r_s3_vld, r_s4_vld, r_s5_vld;
    t_tag                 r_s3_tag, r_s4_tag, r_s5_tag;
    logic [ELAPSED_W-1:0] r_s3_elapsed, r_s4_elapsed;
    logic [PROD_W-1:0]    r_s3_prod, n_s3_prod;
    logic [QUOT_W-1:0]    r_s4_qest, n_s4_qest;
    logic [QM_W-1:0]      r_s4_qm, n_s4_qm;
    logic [QUOT_W-1:0]    r_s5_quot, n_s5_quot;
    logic [RECIP_W-1:0]   w_recip;
    logic [MOD_W-1:0]     w_mod_s3, w_mod_s4;
    logic [QM_W-1:0]      w_rem;

    // multiply by the reciprocal, estimate is low by at most one
    always_comb begin
        w_recip   = i_tag.leap ? RECIP_366 : RECIP_365;
        n_s3_prod = PROD_W'(i_elapsed) * PROD_W'(w_recip);
    end

    // back-multiply the estimate by the divisor
    always_comb begin
        w_mod_s3  = r_s3_tag.leap ? MOD_366 : MOD_365;
        n_s4_qest = r_s3_prod[PROD_W-1:PRESHIFT];
        n_s4_qm   = QM_W'(n_s4_qest) * QM_W'(w_mod_s3);
    end

    // remainder check and one-step correction
    always_comb begin
        w_mod_s4  = r_s4_tag.leap ? MOD_366 : MOD_365;
        w_rem     = QM_W'({r_s4_elapsed, PRESHIFT'(0)}) - r_s4_qm;
        n_s5_quot = r_s4_qest + QUOT_W'(w_rem >= QM_W'(w_mod_s4));
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else if (i_en) begin
            r_s3_vld <= i_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_tag     <= i_tag;
            r_s3_elapsed <= i_elapsed;
            r_s3_prod    <= n_s3_prod;
            r_s4_tag     <= r_s3_tag;
            r_s4_elapsed <= r_s3_elapsed;
            r_s4_qest    <= n_s4_qest;
            r_s4_qm      <= n_s4_qm;
            r_s5_tag     <= r_s4_tag;
            r_s5_quot    <= n_s5_quot;
        end
    end

    assign o_vld  = r_s5_vld;
    assign o_tag  = r_s5_tag;
    assign o_quot = r_s5_quot;

endmodule
